FILE: rtl/x10rf_pkg.sv
// ----------------------------------------------------------------------------
// x10rf_pkg
// Shared constants for the X10 RF pulse-distance transmitter: frame size,
// register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package x10rf_pkg;

   localparam int unsigned FRAME_BITS = 32;
   localparam int unsigned BIT_POS_W  = $clog2(FRAME_BITS);
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned REPEAT_W   = 4;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [TICK_W-1:0]   tick_count_type;
   typedef logic [REPEAT_W-1:0] repeat_count_type;

   // register index (byte address / 4)
   typedef enum logic [2:0] {
      REG_LEADER_HIGH = 3'd0,
      REG_LEADER_LOW  = 3'd1,
      REG_PULSE_HIGH  = 3'd2,
      REG_ZERO_LOW    = 3'd3,
      REG_ONE_LOW     = 3'd4,
      REG_GAP_LOW     = 3'd5,
      REG_REPEAT      = 3'd6,
      REG_UNUSED      = 3'd7
   } reg_index_type;

   localparam tick_count_type   RST_LEADER_HIGH = 16'd9000;
   localparam tick_count_type   RST_LEADER_LOW  = 16'd4500;
   localparam tick_count_type   RST_PULSE_HIGH  = 16'd400;
   localparam tick_count_type   RST_ZERO_LOW    = 16'd800;
   localparam tick_count_type   RST_ONE_LOW     = 16'd2000;
   localparam tick_count_type   RST_GAP_LOW     = 16'd32000;
   localparam repeat_count_type RST_REPEAT      = 4'd6;

   // a zero duration or zero repeat count behaves as one
   function automatic tick_count_type eff_ticks(input tick_count_type v);
      return (v == '0) ? tick_count_type'(1) : v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/x10_rf_pulse_distance_transmitter.sv
// ----------------------------------------------------------------------------
// x10_rf_pulse_distance_transmitter
// X10 RF pulse-distance frame generator, stepped by one-microsecond ticks.
// ----------------------------------------------------------------------------
// Each request transaction is either a tick (req_tuser = 0: one microsecond
// passes) or a start (req_tuser = 1: latch address/command, no time passes).
// Every request yields exactly one response transaction carrying the line
// level, busy flag, end-of-sequence flag and a flag for a start dropped
// because a transmission was already running. A frame is leader high, leader
// low, 32 bits MSB first (address, ~address, command, ~command; each bit a
// pulse followed by a short or long low), a trailer pulse and a gap; it is
// sent repeat_count times. Throughput is one transaction per clock when the
// response side does not stall: a request register feeds the sequencer, whose
// single compare/increment updates the phase state and loads the response
// register in the same cycle. Stalls on the response side back up into the
// request register. Timing registers sit on an APB port
// at byte address 4*index and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module x10_rf_pulse_distance_transmitter (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] address_byte, [15:8] command_byte
   input  wire logic        req_tuser,   // [0] mode: 0 tick, 1 start
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] rf_level, [1] busy_res,
                                         // [2] sequence_done, [3] start_ignored,
                                         // [7:4] zero
   // configuration port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [x10rf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [x10rf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [x10rf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                       csr_pready
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEAD_H  = 3'd1,
      PH_LEAD_L  = 3'd2,
      PH_BIT_H   = 3'd3,
      PH_BIT_L   = 3'd4,
      PH_TRAIL_H = 3'd5,
      PH_GAP_L   = 3'd6
   } phase_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   x10rf_pkg::tick_count_type   leader_high_ff, leader_low_ff, pulse_high_ff;
   x10rf_pkg::tick_count_type   zero_low_ff, one_low_ff, gap_low_ff;
   x10rf_pkg::repeat_count_type repeat_ff;

   x10rf_pkg::reg_index_type csr_index;
   logic                     csr_write;

   assign csr_index  = x10rf_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_high_ff <= x10rf_pkg::RST_LEADER_HIGH;
         leader_low_ff  <= x10rf_pkg::RST_LEADER_LOW;
         pulse_high_ff  <= x10rf_pkg::RST_PULSE_HIGH;
         zero_low_ff    <= x10rf_pkg::RST_ZERO_LOW;
         one_low_ff     <= x10rf_pkg::RST_ONE_LOW;
         gap_low_ff     <= x10rf_pkg::RST_GAP_LOW;
         repeat_ff      <= x10rf_pkg::RST_REPEAT;
      end else if (csr_write) begin
         unique case (csr_index)
            x10rf_pkg::REG_LEADER_HIGH: leader_high_ff <= csr_pwdata[15:0];
            x10rf_pkg::REG_LEADER_LOW:  leader_low_ff  <= csr_pwdata[15:0];
            x10rf_pkg::REG_PULSE_HIGH:  pulse_high_ff  <= csr_pwdata[15:0];
            x10rf_pkg::REG_ZERO_LOW:    zero_low_ff    <= csr_pwdata[15:0];
            x10rf_pkg::REG_ONE_LOW:     one_low_ff     <= csr_pwdata[15:0];
            x10rf_pkg::REG_GAP_LOW:     gap_low_ff     <= csr_pwdata[15:0];
            x10rf_pkg::REG_REPEAT:      repeat_ff      <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         x10rf_pkg::REG_LEADER_HIGH: csr_prdata = {16'd0, leader_high_ff};
         x10rf_pkg::REG_LEADER_LOW:  csr_prdata = {16'd0, leader_low_ff};
         x10rf_pkg::REG_PULSE_HIGH:  csr_prdata = {16'd0, pulse_high_ff};
         x10rf_pkg::REG_ZERO_LOW:    csr_prdata = {16'd0, zero_low_ff};
         x10rf_pkg::REG_ONE_LOW:     csr_prdata = {16'd0, one_low_ff};
         x10rf_pkg::REG_GAP_LOW:     csr_prdata = {16'd0, gap_low_ff};
         x10rf_pkg::REG_REPEAT:      csr_prdata = {28'd0, repeat_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Request register and handshake
   // ------------------------------------------------------------------
   logic       item_valid_ff;
   logic       item_mode_ff;
   logic [7:0] item_addr_ff, item_cmd_ff;
   logic       rsp_valid_ff;
   logic [3:0] rsp_flags_ff;       // {ignored, done, busy, level}
   logic       out_free, advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_flags_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_mode_ff <= req_tuser;
         item_addr_ff <= req_tdata[7:0];
         item_cmd_ff  <= req_tdata[15:8];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   phase_type                        phase_ff, phase_in;
   x10rf_pkg::tick_count_type        count_ff, count_in;
   logic [x10rf_pkg::BIT_POS_W-1:0]  bit_pos_ff, bit_pos_in;
   logic [x10rf_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   x10rf_pkg::repeat_count_type      sent_ff, sent_in;
   logic [3:0]                       flags_in;

   logic                      ph_busy, ph_high, cur_bit, phase_end;
   x10rf_pkg::tick_count_type ph_len;
   x10rf_pkg::repeat_count_type sent_inc;
   logic [x10rf_pkg::TICK_W:0]  count_inc;

   assign ph_busy = (phase_ff != PH_IDLE);
   assign ph_high = (phase_ff == PH_LEAD_H) || (phase_ff == PH_BIT_H) ||
                    (phase_ff == PH_TRAIL_H);
   // MSB first: bit index FRAME_BITS-1-pos
   assign cur_bit = frame_ff[x10rf_pkg::BIT_POS_W'(x10rf_pkg::FRAME_BITS - 1) - bit_pos_ff];

   always_comb begin
      unique case (phase_ff)
         PH_LEAD_H:  ph_len = x10rf_pkg::eff_ticks(leader_high_ff);
         PH_LEAD_L:  ph_len = x10rf_pkg::eff_ticks(leader_low_ff);
         PH_BIT_H:   ph_len = x10rf_pkg::eff_ticks(pulse_high_ff);
         PH_BIT_L:   ph_len = cur_bit ? x10rf_pkg::eff_ticks(one_low_ff)
                                      : x10rf_pkg::eff_ticks(zero_low_ff);
         PH_TRAIL_H: ph_len = x10rf_pkg::eff_ticks(pulse_high_ff);
         PH_GAP_L:   ph_len = x10rf_pkg::eff_ticks(gap_low_ff);
         default:    ph_len = x10rf_pkg::tick_count_type'(1);
      endcase
   end

   assign count_inc = {1'b0, count_ff} + 17'd1;
   assign phase_end = (count_inc >= {1'b0, ph_len});
   assign sent_inc  = sent_ff + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      bit_pos_in = bit_pos_ff;
      frame_in   = frame_ff;
      sent_in    = sent_ff;
      flags_in   = 4'd0;

      if (item_mode_ff) begin
         // start: level/busy reflect the state after the transaction
         if (ph_busy) begin
            flags_in = {1'b1, 1'b0, 1'b1, ph_high};
         end else begin
            frame_in   = {item_addr_ff, ~item_addr_ff, item_cmd_ff, ~item_cmd_ff};
            phase_in   = PH_LEAD_H;
            count_in   = '0;
            bit_pos_in = '0;
            sent_in    = '0;
            flags_in   = {1'b0, 1'b0, 1'b1, 1'b1};
         end
      end else if (ph_busy) begin
         flags_in = {1'b0, 1'b0, 1'b1, ph_high};
         if (phase_end) begin
            count_in = '0;
            unique case (phase_ff)
               PH_LEAD_H: phase_in = PH_LEAD_L;
               PH_LEAD_L: begin
                  phase_in   = PH_BIT_H;
                  bit_pos_in = '0;
               end
               PH_BIT_H: phase_in = PH_BIT_L;
               PH_BIT_L: begin
                  if (bit_pos_ff == x10rf_pkg::BIT_POS_W'(x10rf_pkg::FRAME_BITS - 1)) begin
                     phase_in = PH_TRAIL_H;
                  end else begin
                     bit_pos_in = bit_pos_ff + x10rf_pkg::BIT_POS_W'(1);
                     phase_in   = PH_BIT_H;
                  end
               end
               PH_TRAIL_H: phase_in = PH_GAP_L;
               default: begin
                  // end of gap: next frame or end of sequence
                  bit_pos_in = '0;
                  if (sent_inc == '0 ||
                      sent_inc >= x10rf_pkg::repeat_count_type'(
                                     (repeat_ff == '0) ? 4'd1 : repeat_ff)) begin
                     phase_in    = PH_IDLE;
                     sent_in     = '0;
                     flags_in[2] = 1'b1;
                  end else begin
                     phase_in = PH_LEAD_H;
                     sent_in  = sent_inc;
                  end
               end
            endcase
         end else begin
            count_in = count_inc[x10rf_pkg::TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bit_pos_ff   <= '0;
         frame_ff     <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_flags_ff <= '0;
      end else begin
         if (advance) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            bit_pos_ff   <= bit_pos_in;
            frame_ff     <= frame_in;
            sent_ff      <= sent_in;
            rsp_flags_ff <= flags_in;
         end
         if (out_free) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_flags_imply_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_flags_ff[0] && !rsp_flags_ff[2] && !rsp_flags_ff[3])
                       || rsp_flags_ff[1])
      else $error("response flag set without busy");

   a_done_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_flags_ff[2] && rsp_flags_ff[3]))
      else $error("sequence_done and start_ignored together");

   a_idle_counter_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (count_ff == '0 && sent_ff == '0))
      else $error("idle with stale counters");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && flags_in[2]) |=> (phase_ff == PH_IDLE))
      else $error("sequence end did not return to idle");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(count_ff))
      else $error("sequencer moved without a transaction");

endmodule

`default_nettype wire
